// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/mfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mfe_pkg
// Types and constants shared by the max flow engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfe_pkg;

	localparam int MAX_NODES      = 64;
	localparam int NODE_W         = 6;
	localparam int NCNT_W         = 7;
	localparam int MAX_EDGE_SLOTS = 1024;
	localparam int SLOT_W         = 10;
	localparam int LINK_W         = 11;
	localparam int CAP_W          = 16;
	localparam int FLOW_W         = 26;
	localparam int LVL_W          = 7;
	localparam int CNT_W          = 7;
	localparam int STATUS_W       = 3;
	localparam int CMD_W          = 2;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_EDGE_SLOTS);
	localparam logic [FLOW_W-1:0] FLOW_MAX  = {FLOW_W{1'b1}};

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_RUN   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_CLEARED = 3'd0,
		ST_ADDED   = 3'd1,
		ST_FULL    = 3'd2,
		ST_FLOW    = 3'd3,
		ST_BAD     = 3'd4
	} status_t;

	typedef enum logic [5:0] {
		OP_IDLE, OP_DISP, OP_CLEAR, OP_A1, OP_A2, OP_A3, OP_A4,
		OP_B0, OP_BPOP, OP_BV, OP_BV2, OP_BE, OP_BE2, OP_CI,
		OP_DV, OP_DV2, OP_DE, OP_DE2, OP_DE3, OP_DFAIL, OP_DPOP, OP_DPOP2,
		OP_GINIT, OP_GM1, OP_GM2, OP_GM3, OP_GU1, OP_GU2, OP_GU3, OP_GU4,
		OP_DONE
	} op_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
		logic [CAP_W-1:0]  capacity;
		logic [NODE_W-1:0] source_node;
		logic [NODE_W-1:0] sink_node;
	} req_t;

	typedef struct packed {
		op_t  op;
		logic take;
	} ctl_t;

	typedef struct packed {
		status_t code;
		logic    q_empty;
		logic    snk_reached;
		logic    ci_last;
		logic    edge_null;
		logic    at_sink;
		logic    path_ok;
		logic    lvl_up;
		logic    depth_full;
		logic    depth_zero;
		logic    list_done;
		logic    out_free;
	} stat_t;

endpackage

// ===== design/mfe_if.sv =====
// ----------------------------------------------------------------------------
// mfe_if
// Request and response channels of the max flow engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mfe_req_if;
	import mfe_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [NODE_W-1:0] from_node;
	logic [NODE_W-1:0] to_node;
	logic [CAP_W-1:0]  capacity;
	logic [NODE_W-1:0] source_node;
	logic [NODE_W-1:0] sink_node;

	modport source (output valid, command, from_node, to_node, capacity,
		source_node, sink_node, input ready);
	modport sink (input valid, command, from_node, to_node, capacity,
		source_node, sink_node, output ready);
endinterface

interface mfe_rsp_if;
	import mfe_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FLOW_W-1:0]   flow_value;

	modport source (output valid, status, flow_value, input ready);
	modport sink (input valid, status, flow_value, output ready);
endinterface

// ===== design/mfe_ram.sv =====
// ----------------------------------------------------------------------------
// mfe_ram
// Generic simple dual port RAM, one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/mfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfe_ctrl
// Sequencer: dispatch, clear, edge insert, level search, path search, augment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mfe_pkg::stat_t stat,
	output mfe_pkg::ctl_t  ctl
);
	import mfe_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE, S_DISP, S_CLEAR, S_A1, S_A2, S_A3, S_A4,
		S_B0, S_BPOP, S_BV, S_BV2, S_BE, S_BE2, S_CI,
		S_DV, S_DV2, S_DE, S_DE2, S_DE3, S_DFAIL, S_DPOP, S_DPOP2,
		S_GINIT, S_GM1, S_GM2, S_GM3, S_GU1, S_GU2, S_GU3, S_GU4,
		S_DONE
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (req_valid) state_d = S_DISP;
			S_DISP: begin
				unique case (stat.code)
					ST_CLEARED: state_d = S_CLEAR;
					ST_ADDED:   state_d = S_A1;
					ST_FLOW:    state_d = S_B0;
					default:    state_d = S_DONE;
				endcase
			end
			S_CLEAR: state_d = S_DONE;
			S_A1:    state_d = S_A2;
			S_A2:    state_d = S_A3;
			S_A3:    state_d = S_A4;
			S_A4:    state_d = S_DONE;
			S_B0:    state_d = S_BPOP;
			S_BPOP: begin
				if (stat.q_empty) begin
					state_d = stat.snk_reached ? S_CI : S_DONE;
				end else begin
					state_d = S_BV;
				end
			end
			S_BV:    state_d = S_BV2;
			S_BV2:   state_d = S_BE;
			S_BE:    state_d = stat.edge_null ? S_BPOP : S_BE2;
			S_BE2:   state_d = S_BE;
			S_CI:    state_d = stat.ci_last ? S_DV : S_CI;
			S_DV:    state_d = stat.at_sink ? S_GINIT : S_DV2;
			S_DV2:   state_d = S_DE;
			S_DE:    state_d = stat.edge_null ? S_DFAIL : S_DE2;
			S_DE2:   state_d = stat.path_ok ? S_DE3 : S_DE;
			S_DE3: begin
				if (stat.lvl_up) begin
					state_d = stat.depth_full ? S_DFAIL : S_DV;
				end else begin
					state_d = S_DE;
				end
			end
			S_DFAIL: state_d = stat.depth_zero ? S_B0 : S_DPOP;
			S_DPOP:  state_d = S_DPOP2;
			S_DPOP2: state_d = S_DV;
			S_GINIT: state_d = S_GM1;
			S_GM1:   state_d = stat.list_done ? S_GU1 : S_GM2;
			S_GM2:   state_d = S_GM3;
			S_GM3:   state_d = S_GM1;
			S_GU1:   state_d = stat.list_done ? S_DV : S_GU2;
			S_GU2:   state_d = S_GU3;
			S_GU3:   state_d = S_GU4;
			S_GU4:   state_d = S_GU1;
			S_DONE:  if (stat.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl.take = req_valid && (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE:  ctl.op = OP_IDLE;
			S_DISP:  ctl.op = OP_DISP;
			S_CLEAR: ctl.op = OP_CLEAR;
			S_A1:    ctl.op = OP_A1;
			S_A2:    ctl.op = OP_A2;
			S_A3:    ctl.op = OP_A3;
			S_A4:    ctl.op = OP_A4;
			S_B0:    ctl.op = OP_B0;
			S_BPOP:  ctl.op = OP_BPOP;
			S_BV:    ctl.op = OP_BV;
			S_BV2:   ctl.op = OP_BV2;
			S_BE:    ctl.op = OP_BE;
			S_BE2:   ctl.op = OP_BE2;
			S_CI:    ctl.op = OP_CI;
			S_DV:    ctl.op = OP_DV;
			S_DV2:   ctl.op = OP_DV2;
			S_DE:    ctl.op = OP_DE;
			S_DE2:   ctl.op = OP_DE2;
			S_DE3:   ctl.op = OP_DE3;
			S_DFAIL: ctl.op = OP_DFAIL;
			S_DPOP:  ctl.op = OP_DPOP;
			S_DPOP2: ctl.op = OP_DPOP2;
			S_GINIT: ctl.op = OP_GINIT;
			S_GM1:   ctl.op = OP_GM1;
			S_GM2:   ctl.op = OP_GM2;
			S_GM3:   ctl.op = OP_GM3;
			S_GU1:   ctl.op = OP_GU1;
			S_GU2:   ctl.op = OP_GU2;
			S_GU3:   ctl.op = OP_GU3;
			S_GU4:   ctl.op = OP_GU4;
			S_DONE:  ctl.op = OP_DONE;
			default: ctl.op = OP_IDLE;
		endcase
	end
endmodule

// ===== design/mfe_dp.sv =====
// ----------------------------------------------------------------------------
// mfe_dp
// Datapath: edge and node memories, search registers, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfe_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mfe_pkg::NCNT_W-1:0]    cfg_wdata,
	input  mfe_pkg::ctl_t                 ctl,
	input  mfe_pkg::req_t                 req_pl,
	input  logic                          rsp_ready,
	output mfe_pkg::stat_t                stat,
	output logic                          rsp_valid,
	output logic [mfe_pkg::STATUS_W-1:0]  rsp_status,
	output logic [mfe_pkg::FLOW_W-1:0]    rsp_flow
);
	import mfe_pkg::*;

	// captured request
	logic [NODE_W-1:0] from_q, to_q, src_q, snk_q;
	logic [CAP_W-1:0]  cap_q;
	status_t           code_q, code_d;

	logic [NCNT_W-1:0] ncnt_q, n_eff;
	logic [LINK_W-1:0] used_q;
	logic [MAX_NODES-1:0] vld_q, reached_q;

	logic [CNT_W-1:0]  rd_q, wr_q, depth_q, idx_q, ci_q, ci_m1, depth_m1;
	logic [NODE_W-1:0] v_q, h_q;
	logic [LINK_W-1:0] e_q, nx_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [CAP_W-1:0]  d_q;
	logic [FLOW_W-1:0] total_q;
	logic [FLOW_W:0]   total_sum;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [FLOW_W-1:0] out_flow_q;

	// memory ports
	logic              hd_we, rs_we, nx_we, fe_we, le_we, lv_we, cu_we, qu_we, st_we;
	logic [SLOT_W-1:0] hd_wa, rs_wa, nx_wa, hd_ra, rs_ra, nx_ra;
	logic [NODE_W-1:0] fe_wa, le_wa, lv_wa, cu_wa, qu_wa, st_wa;
	logic [NODE_W-1:0] fe_ra, le_ra, lv_ra, cu_ra, qu_ra, st_ra;
	logic [NODE_W-1:0] hd_wd, hd_rd, qu_wd, qu_rd;
	logic [CAP_W-1:0]  rs_wd, rs_rd;
	logic [LINK_W-1:0] nx_wd, nx_rd, fe_wd, fe_rd, cu_wd, cu_rd;
	logic [SLOT_W-1:0] le_wd, le_rd, st_wd, st_rd;
	logic [LVL_W-1:0]  lv_wd, lv_rd;

	logic [SLOT_W-1:0] slot_k, slot_k1;
	logic [NODE_W-1:0] ci_prev;
	logic              ends_ok, run_ok, tbl_full, bfs_take;

	mfe_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGE_SLOTS)) u_head (.clk(clk), .we(hd_we),
		.waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
	mfe_ram #(.WIDTH(CAP_W), .DEPTH(MAX_EDGE_SLOTS)) u_resid (.clk(clk), .we(rs_we),
		.waddr(rs_wa), .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd));
	mfe_ram #(.WIDTH(LINK_W), .DEPTH(MAX_EDGE_SLOTS)) u_next (.clk(clk), .we(nx_we),
		.waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
	mfe_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_first (.clk(clk), .we(fe_we),
		.waddr(fe_wa), .wdata(fe_wd), .raddr(fe_ra), .rdata(fe_rd));
	mfe_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_last (.clk(clk), .we(le_we),
		.waddr(le_wa), .wdata(le_wd), .raddr(le_ra), .rdata(le_rd));
	mfe_ram #(.WIDTH(LVL_W), .DEPTH(MAX_NODES)) u_level (.clk(clk), .we(lv_we),
		.waddr(lv_wa), .wdata(lv_wd), .raddr(lv_ra), .rdata(lv_rd));
	mfe_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_cursor (.clk(clk), .we(cu_we),
		.waddr(cu_wa), .wdata(cu_wd), .raddr(cu_ra), .rdata(cu_rd));
	mfe_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (.clk(clk), .we(qu_we),
		.waddr(qu_wa), .wdata(qu_wd), .raddr(qu_ra), .rdata(qu_rd));
	mfe_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_stack (.clk(clk), .we(st_we),
		.waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

	assign n_eff    = (ncnt_q > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : ncnt_q;
	assign slot_k   = used_q[SLOT_W-1:0];
	assign slot_k1  = {slot_k[SLOT_W-1:1], 1'b1};
	assign ci_m1    = ci_q - CNT_W'(1);
	assign ci_prev  = ci_m1[NODE_W-1:0];
	assign depth_m1 = depth_q - CNT_W'(1);
	assign total_sum = {1'b0, total_q} + (FLOW_W + 1)'(d_q);

	// request checks, taken at accept
	assign ends_ok  = (NCNT_W'(req_pl.from_node) < n_eff) && (NCNT_W'(req_pl.to_node) < n_eff);
	assign run_ok   = (NCNT_W'(req_pl.source_node) < n_eff)
		&& (NCNT_W'(req_pl.sink_node) < n_eff)
		&& (req_pl.source_node != req_pl.sink_node);
	assign tbl_full = used_q > LINK_W'(MAX_EDGE_SLOTS - 2);

	always_comb begin
		unique case (req_pl.command)
			CMD_CLEAR: code_d = ST_CLEARED;
			CMD_ADD:   code_d = !ends_ok ? ST_BAD : (tbl_full ? ST_FULL : ST_ADDED);
			CMD_RUN:   code_d = run_ok ? ST_FLOW : ST_BAD;
			default:   code_d = ST_BAD;
		endcase
	end

	assign bfs_take = (rs_rd != '0) && (NCNT_W'(hd_rd) < n_eff) && !reached_q[hd_rd]
		&& (wr_q < CNT_W'(MAX_NODES));

	always_comb begin
		stat.code        = code_q;
		stat.q_empty     = (rd_q == wr_q);
		stat.snk_reached = reached_q[snk_q];
		stat.ci_last     = (ci_q == CNT_W'(MAX_NODES));
		stat.edge_null   = (e_q == NULL_LINK);
		stat.at_sink     = (v_q == snk_q);
		stat.path_ok     = (rs_rd != '0) && reached_q[hd_rd];
		stat.lvl_up      = (lvl_q < lv_rd);
		stat.depth_full  = (depth_q == CNT_W'(MAX_NODES));
		stat.depth_zero  = (depth_q == '0);
		stat.list_done   = (idx_q == depth_q);
		stat.out_free    = !out_valid_q || rsp_ready;
	end

	// memory port control
	always_comb begin
		hd_we = 1'b0; rs_we = 1'b0; nx_we = 1'b0; fe_we = 1'b0; le_we = 1'b0;
		lv_we = 1'b0; cu_we = 1'b0; qu_we = 1'b0; st_we = 1'b0;
		hd_wa = '0; rs_wa = '0; nx_wa = '0; hd_ra = '0; rs_ra = '0; nx_ra = '0;
		fe_wa = '0; le_wa = '0; lv_wa = '0; cu_wa = '0; qu_wa = '0; st_wa = '0;
		fe_ra = '0; le_ra = '0; lv_ra = '0; cu_ra = '0; qu_ra = '0; st_ra = '0;
		hd_wd = '0; qu_wd = '0; rs_wd = '0; nx_wd = '0; fe_wd = '0; cu_wd = '0;
		le_wd = '0; st_wd = '0; lv_wd = '0;
		unique case (ctl.op)
			OP_A1: begin
				hd_we = 1'b1; hd_wa = slot_k; hd_wd = to_q;
				rs_we = 1'b1; rs_wa = slot_k; rs_wd = cap_q;
				nx_we = 1'b1; nx_wa = slot_k; nx_wd = NULL_LINK;
				fe_ra = from_q; le_ra = from_q;
			end
			OP_A2: begin
				if (vld_q[from_q]) begin
					nx_we = 1'b1; nx_wa = le_rd; nx_wd = LINK_W'(slot_k);
				end else begin
					fe_we = 1'b1; fe_wa = from_q; fe_wd = LINK_W'(slot_k);
				end
				le_we = 1'b1; le_wa = from_q; le_wd = slot_k;
			end
			OP_A3: begin
				hd_we = 1'b1; hd_wa = slot_k1; hd_wd = from_q;
				rs_we = 1'b1; rs_wa = slot_k1; rs_wd = '0;
				nx_we = 1'b1; nx_wa = slot_k1; nx_wd = NULL_LINK;
				fe_ra = to_q; le_ra = to_q;
			end
			OP_A4: begin
				if (vld_q[to_q]) begin
					nx_we = 1'b1; nx_wa = le_rd; nx_wd = LINK_W'(slot_k1);
				end else begin
					fe_we = 1'b1; fe_wa = to_q; fe_wd = LINK_W'(slot_k1);
				end
				le_we = 1'b1; le_wa = to_q; le_wd = slot_k1;
			end
			OP_B0: begin
				lv_we = 1'b1; lv_wa = src_q; lv_wd = '0;
				qu_we = 1'b1; qu_wa = '0; qu_wd = src_q;
			end
			OP_BPOP: qu_ra = rd_q[NODE_W-1:0];
			OP_BV: begin
				lv_ra = qu_rd; fe_ra = qu_rd;
			end
			OP_BE, OP_DE: begin
				hd_ra = e_q[SLOT_W-1:0]; rs_ra = e_q[SLOT_W-1:0]; nx_ra = e_q[SLOT_W-1:0];
			end
			OP_BE2: begin
				if (bfs_take) begin
					lv_we = 1'b1; lv_wa = hd_rd; lv_wd = lvl_q + LVL_W'(1);
					qu_we = 1'b1; qu_wa = wr_q[NODE_W-1:0]; qu_wd = hd_rd;
				end
			end
			OP_CI: begin
				// read first edge of one node, write the cursor of the node before
				fe_ra = ci_q[NODE_W-1:0];
				if (ci_q != '0) begin
					cu_we = 1'b1; cu_wa = ci_prev;
					cu_wd = vld_q[ci_prev] ? fe_rd : NULL_LINK;
				end
			end
			OP_DV: begin
				cu_ra = v_q; lv_ra = v_q;
			end
			OP_DE2: lv_ra = hd_rd;
			OP_DE3: begin
				if (stat.lvl_up) begin
					cu_we = 1'b1; cu_wa = v_q; cu_wd = e_q;
					if (!stat.depth_full) begin
						st_we = 1'b1; st_wa = depth_q[NODE_W-1:0]; st_wd = e_q[SLOT_W-1:0];
					end
				end
			end
			OP_DFAIL: begin
				cu_we = 1'b1; cu_wa = v_q; cu_wd = e_q;
				st_ra = depth_m1[NODE_W-1:0];
			end
			OP_DPOP: begin
				// tail of the popped edge is the head of its partner
				hd_ra = {st_rd[SLOT_W-1:1], ~st_rd[0]};
				nx_ra = st_rd;
			end
			OP_DPOP2: begin
				cu_we = 1'b1; cu_wa = hd_rd; cu_wd = nx_rd;
			end
			OP_GM1, OP_GU1: st_ra = idx_q[NODE_W-1:0];
			OP_GM2, OP_GU2: rs_ra = st_rd;
			OP_GU3: begin
				rs_we = 1'b1; rs_wa = e_q[SLOT_W-1:0]; rs_wd = rs_rd - d_q;
				rs_ra = {e_q[SLOT_W-1:1], ~e_q[0]};
			end
			OP_GU4: begin
				rs_we = 1'b1; rs_wa = {e_q[SLOT_W-1:1], ~e_q[0]}; rs_wd = rs_rd + d_q;
			end
			default: ;
		endcase
	end

	// control and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncnt_q      <= NCNT_W'(MAX_NODES);
			used_q      <= '0;
			vld_q       <= '0;
			reached_q   <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			depth_q     <= '0;
			idx_q       <= '0;
			ci_q        <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ncnt_q <= cfg_wdata;
			end
			if (ctl.op == OP_DONE && stat.out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctl.op)
				OP_DISP:  total_q <= '0;
				OP_CLEAR: begin
					vld_q  <= '0;
					used_q <= '0;
				end
				OP_A2: vld_q[from_q] <= 1'b1;
				OP_A4: begin
					vld_q[to_q] <= 1'b1;
					used_q      <= used_q + LINK_W'(2);
				end
				OP_B0: begin
					reached_q <= MAX_NODES'(1) << src_q;
					rd_q      <= '0;
					wr_q      <= CNT_W'(1);
					ci_q      <= '0;
				end
				OP_BPOP: if (rd_q != wr_q) rd_q <= rd_q + CNT_W'(1);
				OP_BE2: begin
					if (bfs_take) begin
						reached_q[hd_rd] <= 1'b1;
						wr_q             <= wr_q + CNT_W'(1);
					end
				end
				OP_CI: begin
					ci_q    <= ci_q + CNT_W'(1);
					depth_q <= '0;
				end
				OP_DE3: begin
					if (stat.lvl_up && !stat.depth_full) begin
						depth_q <= depth_q + CNT_W'(1);
					end
				end
				OP_DFAIL: if (depth_q != '0) depth_q <= depth_m1;
				OP_GINIT: idx_q <= '0;
				OP_GM1:   if (stat.list_done) idx_q <= '0;
				OP_GM3:   idx_q <= idx_q + CNT_W'(1);
				OP_GU1: begin
					if (stat.list_done) begin
						depth_q <= '0;
						total_q <= (total_sum >= (FLOW_W + 1)'(FLOW_MAX))
							? FLOW_MAX : total_sum[FLOW_W-1:0];
					end
				end
				OP_GU4: idx_q <= idx_q + CNT_W'(1);
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			from_q <= req_pl.from_node;
			to_q   <= req_pl.to_node;
			cap_q  <= req_pl.capacity;
			src_q  <= req_pl.source_node;
			snk_q  <= req_pl.sink_node;
			code_q <= code_d;
		end
		unique case (ctl.op)
			OP_BV:  v_q <= qu_rd;
			OP_BV2: begin
				lvl_q <= lv_rd;
				e_q   <= vld_q[v_q] ? fe_rd : NULL_LINK;
			end
			OP_BE2: e_q <= nx_rd;
			OP_CI:  v_q <= src_q;
			OP_DV2: begin
				e_q   <= cu_rd;
				lvl_q <= lv_rd;
			end
			OP_DE2: begin
				h_q  <= hd_rd;
				nx_q <= nx_rd;
				if (!stat.path_ok) e_q <= nx_rd;
			end
			OP_DE3: begin
				if (stat.lvl_up) begin
					if (!stat.depth_full) v_q <= h_q;
				end else begin
					e_q <= nx_q;
				end
			end
			OP_DPOP2: v_q <= hd_rd;
			OP_GINIT: d_q <= {CAP_W{1'b1}};
			OP_GM3:   if (rs_rd < d_q) d_q <= rs_rd;
			OP_GU1:   if (stat.list_done) v_q <= src_q;
			OP_GU2:   e_q <= LINK_W'(st_rd);
			OP_DONE: begin
				if (stat.out_free) begin
					out_status_q <= code_q;
					out_flow_q   <= (code_q == ST_FLOW) ? total_q : '0;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_flow   = out_flow_q;

	`ASSERT_ALWAYS(a_depth_bound, clk, arst_n, depth_q <= CNT_W'(MAX_NODES))
	`ASSERT_ALWAYS(a_slots_even, clk, arst_n, !used_q[0] && used_q <= LINK_W'(MAX_EDGE_SLOTS))
	`ASSERT_ALWAYS(a_queue_order, clk, arst_n, rd_q <= wr_q)
	`ASSERT_IMPLY(a_push_nonzero, clk, arst_n, ctl.op == OP_GU3, d_q != '0)
	`ASSERT_NEXT(a_done_out, clk, arst_n, ctl.op == OP_DONE && stat.out_free, out_valid_q)
endmodule

// ===== design/max_flow_engine.sv =====
// ----------------------------------------------------------------------------
// max_flow_engine
// Dinic maximum flow over a stored edge list: clear, add edge, run.
// ----------------------------------------------------------------------------
// Accept to result valid: clear is dispatch, clear, result; add edge is dispatch,
// edge insert, result; a rejected request is dispatch, result. Run: dispatch, then
// per phase a level search over each dequeued node and its edges, a cursor setup
// over every node slot, the path search and two passes over each augmenting path.
// Next word taken in the cycle after the result is loaded; a held result stalls it.
// Reset: asynchronous, graph empty, node count 64; no clearing pass.
`timescale 1ns / 1ps

module max_flow_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mfe_pkg::NCNT_W-1:0] cfg_wdata,
	mfe_req_if.sink                    req,
	mfe_rsp_if.source                  rsp
);
	import mfe_pkg::*;

	req_t  req_pl;
	ctl_t  ctl;
	stat_t stat;

	assign req_pl.command     = req.command;
	assign req_pl.from_node   = req.from_node;
	assign req_pl.to_node     = req.to_node;
	assign req_pl.capacity    = req.capacity;
	assign req_pl.source_node = req.source_node;
	assign req_pl.sink_node   = req.sink_node;

	mfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	mfe_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.ctl        (ctl),
		.req_pl     (req_pl),
		.rsp_ready  (rsp.ready),
		.stat       (stat),
		.rsp_valid  (rsp.valid),
		.rsp_status (rsp.status),
		.rsp_flow   (rsp.flow_value)
	);
endmodule
